// ----- hdl/bhm_pkg.sv -----
`default_nettype none
package bhm_pkg;

   localparam int MAX_WIDTH_DEF = 2048;

   localparam int PIX_W      = 8;
   localparam int DIM_W      = 12;
   localparam int SE_W       = 18;
   localparam int ROW_W      = 12;
   localparam int COL_W      = 11;
   localparam int CMP_W      = 14;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;
   localparam int RSP_DATA_W = 24;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = 2;
   localparam int Q_CNT_W = 3;

   localparam logic [PIX_W-1:0] THRESHOLD_RST = 8'd127;
   localparam logic [DIM_W-1:0] WIDTH_RST     = 12'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RST    = 12'd480;
   localparam logic [SE_W-1:0]  SE_RST        = 18'd174762;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 3'd0,
      CSR_WIDTH     = 3'd1,
      CSR_HEIGHT    = 3'd2,
      CSR_SE        = 3'd3,
      CSR_OR_CENTER = 3'd4
   } csr_index_type;

   // slots: bit0 previous row left of pixel, bit1 previous row end, bit2 last row pixel
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             match_bit;
      logic             mid_bit;
      logic             cur_bit;
      logic             frame_end;
      logic [2:0]       slots;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   // win9: bits 8..6 column c-2, 5..3 column c-1, 2..0 column c; bit2 of a column is top
   function automatic logic se_match(logic [8:0] win9, logic [SE_W-1:0] se);
      logic       hit;
      logic [1:0] e;
      int         k;
      hit = 1'b1;
      for (int kr = 0; kr < 3; kr++) begin
         for (int kc = 0; kc < 3; kc++) begin
            k = kr * 3 + kc;
            e = se[2*k +: 2];
            if (!e[1] && (win9[(2-kc)*3 + (2-kr)] != e[0])) begin
               hit = 1'b0;
            end
         end
      end
      return hit;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/bhm_front.sv -----
`default_nettype none
module bhm_front #(
   parameter int MAX_WIDTH = bhm_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [bhm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [bhm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [bhm_pkg::PIX_W-1:0]       req_tdata,
   input  wire logic                            q_full,
   output bhm_pkg::push_type                    push
);

   localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;

   logic [bhm_pkg::PIX_W-1:0] threshold_ff;
   logic [bhm_pkg::DIM_W-1:0] image_width_ff;
   logic [bhm_pkg::DIM_W-1:0] image_height_ff;
   logic [bhm_pkg::SE_W-1:0]  se_pattern_ff;
   logic                      or_center_ff;

   logic [1:0]                line_mem_ff [MAX_WIDTH];
   logic [1:0]                rd_data_ff;
   logic [CW-1:0]             rd_addr_ff;
   logic [CW-1:0]             rd_addr_in;
   logic                      rd_valid_ff;
   logic                      clear_ff;
   logic [CW-1:0]             clear_addr_ff;

   logic [CW-1:0]             col_ff;
   logic [CW-1:0]             col_in;
   logic [bhm_pkg::ROW_W-1:0] row_ff;
   logic [bhm_pkg::ROW_W-1:0] row_in;
   logic [5:0]                win_ff;

   logic [bhm_pkg::CMP_W-1:0] w_clip;
   logic [bhm_pkg::CMP_W-1:0] w_eff;
   logic [bhm_pkg::DIM_W-1:0] h_eff;
   logic                      restart;
   logic [CW-1:0]             col_cur;
   logic [bhm_pkg::ROW_W-1:0] row_cur;
   logic                      last_col;
   logic                      last_row;
   logic                      accept;
   logic                      bin;
   logic [8:0]                win9;
   logic                      border;
   logic                      match_bit;

   always_comb begin
      w_clip  = (bhm_pkg::CMP_W'(image_width_ff) > bhm_pkg::CMP_W'(MAX_WIDTH))
              ? bhm_pkg::CMP_W'(MAX_WIDTH) : bhm_pkg::CMP_W'(image_width_ff);
      w_eff   = (w_clip < bhm_pkg::CMP_W'(3)) ? bhm_pkg::CMP_W'(3) : w_clip;
      h_eff   = (image_height_ff < bhm_pkg::DIM_W'(3)) ? bhm_pkg::DIM_W'(3) : image_height_ff;
      restart = (bhm_pkg::CMP_W'(col_ff) >= w_eff) || (row_ff >= h_eff);
      col_cur = restart ? '0 : col_ff;
      row_cur = restart ? '0 : row_ff;

      last_col = (bhm_pkg::CMP_W'(col_cur) == (w_eff - bhm_pkg::CMP_W'(1)));
      last_row = (row_cur == (h_eff - bhm_pkg::DIM_W'(1)));

      req_tready = rd_valid_ff && (rd_addr_ff == col_cur) && !q_full;
      accept     = req_tvalid && req_tready;

      col_in = last_col ? '0 : col_cur + CW'(1);
      row_in = last_col ? (last_row ? '0 : row_cur + bhm_pkg::ROW_W'(1)) : row_cur;
      rd_addr_in = accept ? col_in : col_cur;

      bin       = (req_tdata >= threshold_ff);
      win9      = {win_ff, rd_data_ff[1], rd_data_ff[0], bin};
      border    = (row_cur == bhm_pkg::ROW_W'(1)) || (col_cur == CW'(1));
      match_bit = border ? win9[4]
                : (bhm_pkg::se_match(win9, se_pattern_ff) | (or_center_ff & win9[4]));

      push.valid           = '0;
      push.job.row         = row_cur;
      push.job.col         = bhm_pkg::COL_W'(col_cur);
      push.job.match_bit   = match_bit;
      push.job.mid_bit     = rd_data_ff[0];
      push.job.cur_bit     = bin;
      push.job.frame_end   = last_col;
      push.job.slots[0]    = (row_cur != '0) && (col_cur != '0);
      push.job.slots[1]    = (row_cur != '0) && last_col;
      push.job.slots[2]    = last_row;
      push.valid           = accept && (push.job.slots != 3'b000);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff    <= bhm_pkg::THRESHOLD_RST;
         image_width_ff  <= bhm_pkg::WIDTH_RST;
         image_height_ff <= bhm_pkg::HEIGHT_RST;
         se_pattern_ff   <= bhm_pkg::SE_RST;
         or_center_ff    <= 1'b0;
      end else if (csr_we) begin
         case (bhm_pkg::csr_index_type'(csr_index))
            bhm_pkg::CSR_THRESHOLD: begin
               threshold_ff <= csr_wdata[bhm_pkg::PIX_W-1:0];
            end
            bhm_pkg::CSR_WIDTH: begin
               image_width_ff <= csr_wdata[bhm_pkg::DIM_W-1:0];
            end
            bhm_pkg::CSR_HEIGHT: begin
               image_height_ff <= csr_wdata[bhm_pkg::DIM_W-1:0];
            end
            bhm_pkg::CSR_SE: begin
               se_pattern_ff <= csr_wdata[bhm_pkg::SE_W-1:0];
            end
            bhm_pkg::CSR_OR_CENTER: begin
               or_center_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         win_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         rd_addr_ff    <= '0;
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         rd_valid_ff <= !clear_ff;
         rd_addr_ff  <= rd_addr_in;
         if (clear_ff) begin
            clear_addr_ff <= clear_addr_ff + CW'(1);
            if (clear_addr_ff == CW'(MAX_WIDTH - 1)) begin
               clear_ff <= 1'b0;
            end
         end
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
            win_ff <= win9[5:0];
         end
      end
   end

   // zeroed after reset; next column is prefetched, so a pixel write and a read never hit the same entry
   always_ff @(posedge clock) begin
      if (clear_ff) begin
         line_mem_ff[clear_addr_ff] <= '0;
      end else if (accept) begin
         line_mem_ff[col_cur] <= {rd_data_ff[0], bin};
      end
      rd_data_ff <= line_mem_ff[rd_addr_in];
   end

   a_no_ready_clearing: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !req_tready)
      else $error("pixel accepted while line store clears");

   a_push_has_slot: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> (push.job.slots != 3'b000))
      else $error("job pushed with no result");

   a_position_in_frame: assert property (@(posedge clock) disable iff (reset)
      accept |-> (bhm_pkg::CMP_W'(col_cur) < w_eff) && (row_cur < h_eff))
      else $error("pixel position outside frame");

endmodule
`default_nettype wire

// ----- hdl/bhm_queue.sv -----
`default_nettype none
module bhm_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire bhm_pkg::push_type  push,
   output logic                    full,
   input  wire logic               pop,
   output logic                    empty,
   output bhm_pkg::job_type        head
);

   bhm_pkg::job_type            q_mem_ff [bhm_pkg::Q_DEPTH];
   logic [bhm_pkg::Q_PTR_W-1:0] wr_ptr_ff;
   logic [bhm_pkg::Q_PTR_W-1:0] rd_ptr_ff;
   logic [bhm_pkg::Q_CNT_W-1:0] count_ff;
   logic [bhm_pkg::Q_CNT_W-1:0] count_in;
   logic                        do_push;
   logic                        do_pop;

   always_comb begin
      full    = (count_ff == bhm_pkg::Q_CNT_W'(bhm_pkg::Q_DEPTH));
      empty   = (count_ff == '0);
      head    = q_mem_ff[rd_ptr_ff];
      do_push = push.valid && !full;
      do_pop  = pop && !empty;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + bhm_pkg::Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - bhm_pkg::Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + bhm_pkg::Q_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + bhm_pkg::Q_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_mem_ff[wr_ptr_ff] <= push.job;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push.valid && full))
      else $error("job pushed into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("job popped from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= bhm_pkg::Q_CNT_W'(bhm_pkg::Q_DEPTH))
      else $error("queue count beyond depth");

endmodule
`default_nettype wire

// ----- hdl/bhm_back.sv -----
`default_nettype none
module bhm_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             empty,
   input  wire bhm_pkg::job_type                 head,
   output logic                                  pop,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [bhm_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                  rsp_tlast
);

   logic [2:0]                done_ff;
   logic [2:0]                done_in;
   logic [2:0]                remain;
   logic [2:0]                sel;
   logic [2:0]                after;
   logic                      load;
   logic                      out_valid_ff;
   logic [bhm_pkg::ROW_W-1:0] out_row_ff;
   logic [bhm_pkg::COL_W-1:0] out_col_ff;
   logic                      out_bit_ff;
   logic                      out_last_ff;
   logic [bhm_pkg::ROW_W-1:0] row_in;
   logic [bhm_pkg::COL_W-1:0] col_in;
   logic                      bit_in;
   logic                      last_in;

   always_comb begin
      remain = head.slots & ~done_ff;
      if (remain[0]) begin
         sel = 3'b001;
      end else if (remain[1]) begin
         sel = 3'b010;
      end else begin
         sel = 3'b100;
      end
      after = remain & ~sel;
      load  = !empty && (!out_valid_ff || rsp_tready);
      pop   = load && (after == 3'b000);
      done_in = done_ff;
      if (load) begin
         done_in = (after == 3'b000) ? 3'b000 : (done_ff | sel);
      end

      row_in  = head.row - bhm_pkg::ROW_W'(1);
      col_in  = head.col - bhm_pkg::COL_W'(1);
      bit_in  = head.match_bit;
      last_in = 1'b0;
      if (sel[1]) begin
         col_in = head.col;
         bit_in = head.mid_bit;
      end else if (sel[2]) begin
         row_in  = head.row;
         col_in  = head.col;
         bit_in  = head.cur_bit;
         last_in = head.frame_end;
      end

      rsp_tvalid = out_valid_ff;
      rsp_tdata  = {out_bit_ff, out_col_ff, out_row_ff};
      rsp_tlast  = out_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_row_ff  <= row_in;
         out_col_ff  <= col_in;
         out_bit_ff  <= bit_in;
         out_last_ff <= last_in;
      end
   end

   a_done_clear_idle: assert property (@(posedge clock) disable iff (reset)
      empty |-> (done_ff == 3'b000))
      else $error("slot marks left with no job");

   a_done_in_job: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ((done_ff & ~head.slots) == 3'b000) && (remain != 3'b000))
      else $error("slot marks do not fit head job");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> out_valid_ff)
      else $error("loaded result not presented");

endmodule
`default_nettype wire

// ----- hdl/binary_hit_or_miss_3x3_top.sv -----
`default_nettype none
// Binary 3x3 hit-or-miss filter. Gray pixels enter on req_ in raster order, one word per
// clock, and are binarized (pixel >= threshold). Results leave on rsp_ one row behind,
// with their coordinates; a pixel produces zero to three results, and the last result of
// a frame carries rsp_tlast. With rsp_tready high, the sustained rate outside the last row
// is one pixel and one result per clock. A row-end pixel past the first row, or a last-row
// pixel past the first column, has two or three results, which leave one per clock through
// the single output register; the input stalls when the four-entry job queue fills. After
// reset the line store (MAX_WIDTH entries of two bits, one read and one write port) is
// zeroed one entry per clock, and req_tready stays low until the store is cleared. The
// store is prefetched one column ahead, so after a size write that restarts the frame
// mid-row the first pixel waits for the refetch. Write registers only while idle.
module binary_hit_or_miss_3x3_top #(
   parameter int MAX_WIDTH = bhm_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [bhm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bhm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [bhm_pkg::PIX_W-1:0]        req_tdata,   // [7:0] pixel_value
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // rsp_tdata: [11:0] out_row, [22:12] out_col, [23] out_bit
   output logic [bhm_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                  rsp_tlast
);

   bhm_pkg::push_type push;
   bhm_pkg::job_type  head;
   logic              q_full;
   logic              q_empty;
   logic              q_pop;

   bhm_front #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .push       (push)
   );

   bhm_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (q_full),
      .pop   (q_pop),
      .empty (q_empty),
      .head  (head)
   );

   bhm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (q_empty),
      .head       (head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
`default_nettype none
module testbench;
   import bhm_pkg::*;

   localparam int LINE_LEN = MAX_WIDTH_DEF;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             fg;
      logic             last;
   } pixel_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   binary_hit_or_miss_3x3_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // filter state and register copy
   logic [1:0]       rows_above [LINE_LEN];
   logic [5:0]       win_hist;
   int unsigned      col_pos;
   int unsigned      row_pos;
   logic [PIX_W-1:0] thr_cfg;
   logic [DIM_W-1:0] width_cfg;
   logic [DIM_W-1:0] height_cfg;
   logic [SE_W-1:0]  se_cfg;
   logic             thicken_cfg;

   pixel_result_type expected_pixels [$];

   bit steady = 1'b0;
   int errors = 0;
   int items_sent = 0;
   int results_checked = 0;
   int frame_ends = 0;
   int fg_results = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("testbench: FAIL");
      $finish;
   end

   task automatic reset_model();
      for (int i = 0; i < LINE_LEN; i++) begin
         rows_above[i] = 2'b00;
      end
      win_hist    = '0;
      col_pos     = 0;
      row_pos     = 0;
      thr_cfg     = THRESHOLD_RST;
      width_cfg   = WIDTH_RST;
      height_cfg  = HEIGHT_RST;
      se_cfg      = SE_RST;
      thicken_cfg = 1'b0;
   endtask

   function automatic logic window_hits(input logic [8:0] win);
      logic [1:0] e;
      logic       hit;
      hit = 1'b1;
      for (int k = 0; k < 9; k++) begin
         e = se_cfg[2*k +: 2];
         if (!e[1] && win[(2 - k % 3) * 3 + (2 - k / 3)] != e[0]) begin
            hit = 1'b0;
         end
      end
      return hit;
   endfunction

   function automatic void expect_result(input int unsigned r, input int unsigned c,
                                         input logic fg, input logic last);
      pixel_result_type res;
      res.row  = r[ROW_W-1:0];
      res.col  = c[COL_W-1:0];
      res.fg   = fg;
      res.last = last;
      expected_pixels = {expected_pixels, res};
   endfunction

   function automatic void filter_pixel(input logic [PIX_W-1:0] pix);
      int unsigned w, h, r, c;
      logic        b, top, mid, centre, v;
      logic [8:0]  win;
      w = 32'(width_cfg);
      h = 32'(height_cfg);
      if (w > LINE_LEN) w = LINE_LEN;
      if (w < 3) w = 3;
      if (h < 3) h = 3;
      if (col_pos >= w || row_pos >= h) begin
         col_pos = 0;
         row_pos = 0;
      end
      r = row_pos;
      c = col_pos;
      b = (pix >= thr_cfg);
      top = rows_above[c][1];
      mid = rows_above[c][0];
      rows_above[c] = {mid, b};
      win = {win_hist, top, mid, b};
      win_hist = win[5:0];
      centre = win[4];
      if (r >= 1) begin
         if (c >= 1) begin
            if (r == 1 || c == 1) begin
               v = centre;
            end else begin
               v = window_hits(win) | (thicken_cfg & centre);
            end
            expect_result(r - 1, c - 1, v, 1'b0);
         end
         if (c == w - 1) expect_result(r - 1, c, mid, 1'b0);
      end
      if (r == h - 1) expect_result(r, c, b, c == w - 1);
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endfunction

   function automatic logic [PIX_W-1:0] rand_pixel();
      logic [PIX_W-1:0] p;
      p = PIX_W'($urandom_range(0, 255));
      if ($urandom_range(0, 3) != 0) begin
         if ($urandom_range(0, 1) == 1 || thr_cfg == 0) begin
            p = PIX_W'($urandom_range(32'(thr_cfg), 255));
         end else begin
            p = PIX_W'($urandom_range(0, 32'(thr_cfg) - 1));
         end
      end
      return p;
   endfunction

   function automatic logic [SE_W-1:0] rand_se();
      logic [SE_W-1:0] s;
      logic [1:0]      e;
      for (int k = 0; k < 9; k++) begin
         e = 2'($urandom_range(0, 3));
         if ($urandom_range(0, 4) < 3) e[1] = 1'b1;
         s[2*k +: 2] = e;
      end
      return s;
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_THRESHOLD: thr_cfg     = val[PIX_W-1:0];
         CSR_WIDTH:     width_cfg   = val[DIM_W-1:0];
         CSR_HEIGHT:    height_cfg  = val[DIM_W-1:0];
         CSR_SE:        se_cfg      = val[SE_W-1:0];
         CSR_OR_CENTER: thicken_cfg = val[0];
         default: ;
      endcase
   endtask

   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 37) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      do @(posedge clock); while (req_tready !== 1'b1);
      filter_pixel(pix);
      items_sent++;
   endtask

   // let the block run dry before touching registers
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   initial begin : check_results
      pixel_result_type got, want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
            got.row  = rsp_tdata[11:0];
            got.col  = rsp_tdata[22:12];
            got.fg   = rsp_tdata[23];
            got.last = rsp_tlast;
            if (expected_pixels.size() == 0) begin
               errors++;
               $display("%0t: unexpected word row %0d col %0d fg %0b last %0b",
                        $time, got.row, got.col, got.fg, got.last);
            end else begin
               want = expected_pixels.pop_front();
               results_checked++;
               if (got.last) frame_ends++;
               if (got.fg) fg_results++;
               if (got.row !== want.row || got.col !== want.col ||
                   got.fg !== want.fg || got.last !== want.last) begin
                  errors++;
                  $display("%0t: expected row %0d col %0d fg %0b last %0b, %s",
                           $time, want.row, want.col, want.fg, want.last,
                           $sformatf("got row %0d col %0d fg %0b last %0b",
                                     got.row, got.col, got.fg, got.last));
               end
            end
         end
         @(negedge clock);
         rsp_tready <= steady || ($urandom_range(0, 99) >= 37);
      end
   end

   task automatic test_border_passthrough();
      logic [PIX_W-1:0] pix [9];
      pix = '{8'd0, 8'd255, 8'd127, 8'd128, 8'd126, 8'd255, 8'd1, 8'd254, 8'd127};
      write_csr(CSR_WIDTH, CSR_DATA_W'(3));
      write_csr(CSR_HEIGHT, CSR_DATA_W'(3));
      write_csr(CSR_THRESHOLD, CSR_DATA_W'(127));
      foreach (pix[i]) send_pixel(pix[i]);
      drain();
   endtask

   // all-background SE with thickening; one lit pixel inside the frame
   task automatic test_match_thicken();
      write_csr(CSR_WIDTH, CSR_DATA_W'(4));
      write_csr(CSR_HEIGHT, CSR_DATA_W'(4));
      write_csr(CSR_THRESHOLD, CSR_DATA_W'(255));
      write_csr(CSR_SE, CSR_DATA_W'(0));
      write_csr(CSR_OR_CENTER, CSR_DATA_W'(1));
      for (int i = 0; i < 16; i++) begin
         send_pixel((i == 9) ? 8'd255 : (i == 15) ? 8'd254 : 8'd0);
      end
      drain();
   endtask

   task automatic test_size_clamping();
      write_csr(CSR_WIDTH, CSR_DATA_W'(2));
      write_csr(CSR_HEIGHT, CSR_DATA_W'(1));
      write_csr(CSR_THRESHOLD, CSR_DATA_W'(0));
      write_csr(CSR_SE, 18'h3FFFF);
      write_csr(CSR_OR_CENTER, CSR_DATA_W'(0));
      repeat (9) send_pixel(rand_pixel());
      drain();
      write_csr(CSR_WIDTH, CSR_DATA_W'(0));
      write_csr(CSR_HEIGHT, CSR_DATA_W'(0));
      write_csr(CSR_THRESHOLD, CSR_DATA_W'(255));
      repeat (9) send_pixel(rand_pixel());
      drain();
   endtask

   task automatic test_spare_index();
      for (int i = CSR_OR_CENTER + 1; i < (1 << CSR_IDX_W); i++) begin
         write_csr(CSR_IDX_W'(i), CSR_DATA_W'($urandom_range(0, 18'h3FFFF)));
      end
      write_csr(CSR_THRESHOLD, CSR_DATA_W'(100));
      repeat (9) send_pixel(rand_pixel());
      drain();
   endtask

   // shrink the frame while the position lies beyond the new size
   task automatic test_resize_mid_frame();
      write_csr(CSR_WIDTH, CSR_DATA_W'(8));
      write_csr(CSR_HEIGHT, CSR_DATA_W'(5));
      write_csr(CSR_SE, rand_se());
      repeat (13) send_pixel(rand_pixel());
      drain();
      write_csr(CSR_WIDTH, CSR_DATA_W'(4));
      repeat (20) send_pixel(rand_pixel());
      drain();
      write_csr(CSR_WIDTH, CSR_DATA_W'(6));
      write_csr(CSR_HEIGHT, CSR_DATA_W'(6));
      repeat (26) send_pixel(rand_pixel());
      drain();
      write_csr(CSR_HEIGHT, CSR_DATA_W'(3));
      repeat (18) send_pixel(rand_pixel());
      drain();
   endtask

   // start of a width-clamped frame, no stalls
   task automatic test_wide_frame();
      write_csr(CSR_WIDTH, CSR_DATA_W'(4095));
      write_csr(CSR_HEIGHT, CSR_DATA_W'(2));
      write_csr(CSR_THRESHOLD, CSR_DATA_W'($urandom_range(1, 254)));
      write_csr(CSR_SE, rand_se());
      write_csr(CSR_OR_CENTER, CSR_DATA_W'(1));
      steady = 1'b1;
      repeat (24) send_pixel(rand_pixel());
      drain();
      steady = 1'b0;
   endtask

   // narrow rows of a tall frame, no stalls
   task automatic test_tall_frame();
      write_csr(CSR_WIDTH, CSR_DATA_W'(1));
      write_csr(CSR_HEIGHT, CSR_DATA_W'(4095));
      write_csr(CSR_THRESHOLD, CSR_DATA_W'($urandom_range(1, 254)));
      write_csr(CSR_SE, rand_se());
      write_csr(CSR_OR_CENTER, CSR_DATA_W'(0));
      steady = 1'b1;
      repeat (60) send_pixel(rand_pixel());
      drain();
      steady = 1'b0;
   endtask

   task automatic test_random_frames();
      int unsigned sent, w, h, ew, eh, n;
      logic [5:0]  junk;
      sent = 0;
      while (sent < 270) begin
         drain();
         case ($urandom_range(0, 19))
            0:       w = LINE_LEN;
            1, 2:    w = $urandom_range(0, 2);
            default: w = $urandom_range(3, 9);
         endcase
         h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
         junk = 6'($urandom_range(0, 63));
         if ($urandom_range(0, 3) != 0) begin
            write_csr(CSR_WIDTH, {junk, w[DIM_W-1:0]});
            write_csr(CSR_HEIGHT, {junk, h[DIM_W-1:0]});
         end
         write_csr(CSR_THRESHOLD, CSR_DATA_W'($urandom_range(0, 255)));
         write_csr(CSR_SE, ($urandom_range(0, 9) == 0)
                           ? CSR_DATA_W'($urandom_range(0, 18'h3FFFF)) : rand_se());
         write_csr(CSR_OR_CENTER, CSR_DATA_W'($urandom_range(0, 1)));
         ew = (width_cfg > LINE_LEN) ? LINE_LEN : (width_cfg < 3) ? 3 : 32'(width_cfg);
         eh = (height_cfg < 3) ? 3 : 32'(height_cfg);
         if (ew > 9) begin
            n = $urandom_range(1, 40);
         end else if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, ew * eh);
         end else begin
            n = ew * eh;
         end
         steady = ($urandom_range(0, 7) == 0);
         repeat (n) send_pixel(rand_pixel());
         steady = 1'b0;
         sent += n;
      end
   endtask

   initial begin
      reset_model();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_border_passthrough();
      test_match_thicken();
      test_size_clamping();
      test_spare_index();
      test_resize_mid_frame();
      test_wide_frame();
      test_tall_frame();
      test_random_frames();
      drain();
      $display("testbench: %0d pixels sent, %0d results checked (%0d foreground, %0d frame ends)",
               items_sent, results_checked, fg_results, frame_ends);
      $display("testbench: clamped and random sizes, starts of 2048-wide and tall frames, %0d errors",
               errors);
      if (errors == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
